[design/shuffled_triple_lcg_generator_unit_macros.svh]
// assertion macros for the shuffled triple lcg generator checker
// expects clk and arst_n in the scope where a macro is used
`ifndef SHUFFLED_TRIPLE_LCG_GENERATOR_UNIT_MACROS_SVH
`define SHUFFLED_TRIPLE_LCG_GENERATOR_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define STLG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stlg check failed");

// condition implies consequence in the next cycle
`define STLG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stlg check failed");

`endif

[design/stlg_pkg.sv]
// shared constants, types and state encoding of the shuffled triple lcg generator
// no dependencies
package stlg_pkg;

	localparam int GEN_W       = 18;
	localparam int SEED_W      = 32;
	localparam int X_W         = 35;
	localparam int RCP_W       = 18;
	localparam int Q_W         = RCP_W;
	localparam int MUL_W       = 13;
	localparam int ADD_W       = 16;
	localparam int TABLE_DEPTH = 97;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int PAIR_W      = 2 * GEN_W;

	localparam logic [GEN_W-1:0] MOD_ONE   = 18'd259200;
	localparam logic [GEN_W-1:0] MOD_TWO   = 18'd134456;
	localparam logic [GEN_W-1:0] MOD_THREE = 18'd243000;

	localparam logic [MUL_W-1:0] MUL_ONE   = 13'd7141;
	localparam logic [MUL_W-1:0] MUL_TWO   = 13'd8121;
	localparam logic [MUL_W-1:0] MUL_THREE = 13'd4561;
	localparam logic [MUL_W-1:0] MUL_SLOT  = MUL_W'(TABLE_DEPTH);

	localparam logic [ADD_W-1:0] ADD_ONE   = 16'd54773;
	localparam logic [ADD_W-1:0] ADD_TWO   = 16'd28411;
	localparam logic [ADD_W-1:0] ADD_THREE = 16'd51349;

	// floor(2^X_W / m) for each modulus
	localparam logic [RCP_W-1:0] RCP_ONE   = RCP_W'((64'd1 << X_W) / 64'(MOD_ONE));
	localparam logic [RCP_W-1:0] RCP_TWO   = RCP_W'((64'd1 << X_W) / 64'(MOD_TWO));
	localparam logic [RCP_W-1:0] RCP_THREE = RCP_W'((64'd1 << X_W) / 64'(MOD_THREE));

	// multiple of MOD_ONE that lifts any seed difference above zero
	localparam logic [X_W-1:0] SEED_BIAS = X_W'(((64'd1 << (SEED_W - 1)) + 64'(MOD_ONE)
		- 64'd1) / 64'(MOD_ONE) * 64'(MOD_ONE));

	typedef enum logic [2:0] {
		OP_SEED,
		OP_STEP1,
		OP_STEP2,
		OP_STEP3,
		OP_DER2,
		OP_DER3,
		OP_SLOT
	} stlg_op_t;

	typedef struct packed {
		logic           valid;
		stlg_op_t       op;
		logic [X_W-1:0] x;
	} stlg_mreq_t;

	typedef struct packed {
		logic             valid;
		stlg_op_t         op;
		logic [GEN_W-1:0] rem;
		logic [Q_W-1:0]   quo;
	} stlg_mres_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SD_RAW,
		ST_SD_RAW_W,
		ST_SD_S1A,
		ST_SD_S1A_W,
		ST_SD_D2,
		ST_SD_S1B,
		ST_SD_S1B_W,
		ST_SD_D3,
		ST_FL_S1,
		ST_FL_S2,
		ST_FL_W,
		ST_DR_S1,
		ST_DR_S2,
		ST_DR_S3,
		ST_DR_W,
		ST_DR_SL,
		ST_DR_SL_W,
		ST_DR_RD,
		ST_DR_OUT
	} stlg_state_t;

endpackage

[design/stlg_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module stlg_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 97,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/stlg_modred.sv]
// pipelined multiply-add and constant modulo unit, result registered in stage s4
// depends on stlg_pkg
module stlg_modred (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stlg_pkg::stlg_mreq_t   mreq,
	output stlg_pkg::stlg_mres_t   mres
);

	localparam int P_W = stlg_pkg::X_W + stlg_pkg::RCP_W;
	localparam int R_W = stlg_pkg::GEN_W + 1;

	function automatic logic use_mul(input stlg_pkg::stlg_op_t op);
		logic res;
		case (op) inside
			stlg_pkg::OP_STEP1, stlg_pkg::OP_STEP2, stlg_pkg::OP_STEP3,
			stlg_pkg::OP_SLOT: res = 1'b1;
			default: res = 1'b0;
		endcase
		return res;
	endfunction

	function automatic logic [stlg_pkg::MUL_W-1:0] mul_of(input stlg_pkg::stlg_op_t op);
		logic [stlg_pkg::MUL_W-1:0] res;
		case (op)
			stlg_pkg::OP_STEP1: res = stlg_pkg::MUL_ONE;
			stlg_pkg::OP_STEP2: res = stlg_pkg::MUL_TWO;
			stlg_pkg::OP_STEP3: res = stlg_pkg::MUL_THREE;
			stlg_pkg::OP_SLOT:  res = stlg_pkg::MUL_SLOT;
			default:            res = '0;
		endcase
		return res;
	endfunction

	function automatic logic [stlg_pkg::ADD_W-1:0] add_of(input stlg_pkg::stlg_op_t op);
		logic [stlg_pkg::ADD_W-1:0] res;
		case (op)
			stlg_pkg::OP_STEP1: res = stlg_pkg::ADD_ONE;
			stlg_pkg::OP_STEP2: res = stlg_pkg::ADD_TWO;
			stlg_pkg::OP_STEP3: res = stlg_pkg::ADD_THREE;
			default:            res = '0;
		endcase
		return res;
	endfunction

	function automatic logic [stlg_pkg::GEN_W-1:0] mod_of(input stlg_pkg::stlg_op_t op);
		logic [stlg_pkg::GEN_W-1:0] res;
		case (op) inside
			stlg_pkg::OP_STEP2, stlg_pkg::OP_DER2: res = stlg_pkg::MOD_TWO;
			stlg_pkg::OP_STEP3, stlg_pkg::OP_DER3,
			stlg_pkg::OP_SLOT: res = stlg_pkg::MOD_THREE;
			default: res = stlg_pkg::MOD_ONE;
		endcase
		return res;
	endfunction

	function automatic logic [stlg_pkg::RCP_W-1:0] rcp_of(input stlg_pkg::stlg_op_t op);
		logic [stlg_pkg::RCP_W-1:0] res;
		case (op) inside
			stlg_pkg::OP_STEP2, stlg_pkg::OP_DER2: res = stlg_pkg::RCP_TWO;
			stlg_pkg::OP_STEP3, stlg_pkg::OP_DER3,
			stlg_pkg::OP_SLOT: res = stlg_pkg::RCP_THREE;
			default: res = stlg_pkg::RCP_ONE;
		endcase
		return res;
	endfunction

	logic                         v_s1, v_s2, v_s3, v_s4;
	stlg_pkg::stlg_op_t           op_s1, op_s2, op_s3, op_s4;
	logic [stlg_pkg::X_W-1:0]     x_s1, x_s2;
	logic [stlg_pkg::Q_W-1:0]     q_s2, q_s3, quo_s4;
	logic [R_W-1:0]               r_s3;
	logic [stlg_pkg::GEN_W-1:0]   rem_s4;

	logic [31:0]                  lin;
	logic [stlg_pkg::X_W-1:0]     x_in;
	logic [P_W-1:0]               prod;
	logic [2*stlg_pkg::GEN_W-1:0] qm;
	logic [stlg_pkg::X_W-1:0]     diff;
	logic [R_W-1:0]               mod_ext;

	assign mres = '{valid: v_s4, op: op_s4, rem: rem_s4, quo: quo_s4};

	always_comb begin
		lin     = 32'(mul_of(mreq.op)) * 32'(mreq.x[stlg_pkg::GEN_W-1:0])
			+ 32'(add_of(mreq.op));
		x_in    = use_mul(mreq.op) ? stlg_pkg::X_W'(lin) : mreq.x;
		prod    = P_W'(x_s1) * P_W'(rcp_of(op_s1));
		qm      = (2*stlg_pkg::GEN_W)'(q_s2) * (2*stlg_pkg::GEN_W)'(mod_of(op_s2));
		diff    = x_s2 - stlg_pkg::X_W'(qm);
		mod_ext = R_W'(mod_of(op_s3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= mreq.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= mreq.op;
		x_s1  <= x_in;
		op_s2 <= op_s1;
		x_s2  <= x_s1;
		q_s2  <= prod[P_W-1:stlg_pkg::X_W];
		op_s3 <= op_s2;
		q_s3  <= q_s2;
		r_s3  <= diff[R_W-1:0];
		op_s4 <= op_s3;
		if (r_s3 >= mod_ext) begin
			rem_s4 <= stlg_pkg::GEN_W'(r_s3 - mod_ext);
			quo_s4 <= q_s3 + 1'b1;
		end else begin
			rem_s4 <= r_s3[stlg_pkg::GEN_W-1:0];
			quo_s4 <= q_s3;
		end
	end

endmodule

[design/shuffled_triple_lcg_generator_unit.sv]
// top level of the shuffled triple lcg generator: sequencer, generator registers, shuffle table
// depends on stlg_pkg, stlg_ram, stlg_modred
//
// usage
// request channel: req_valid, req_stall, req_type, seed. a request is taken at a rising
// edge with req_valid high and req_stall low. req_type 0 draws, 1 reseeds from seed and
// then draws; the first request after reset always reseeds.
// result channel: res_valid, res_stall, coarse, fine. one result per request, the pair
// leaves through an output register and holds while res_stall is high.
// one request is in work at a time; req_stall is high from acceptance until the result
// has been loaded into the output register, which may still be waiting to be taken.
// a draw runs three generator steps through the four-stage shared modulo pipeline, then a
// slot pass through it and the table read. a reseed first reduces the seed, derives the
// generators and refills every table entry, each step waiting on the result it depends on.
// the next request can be taken in the same cycle in which res_valid rises.
// if res_stall holds a previous result, the new result waits in the ST_DR_OUT state.
// reset clears the generators, the seeded flag and the output valid; the table contents
// are left as they are and are refilled by the first request.
module shuffled_triple_lcg_generator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              req_type,
	input  logic signed [stlg_pkg::SEED_W-1:0] seed,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [stlg_pkg::GEN_W-1:0]        coarse,
	output logic [stlg_pkg::GEN_W-1:0]        fine
);

	stlg_pkg::stlg_state_t          state_q, state_d;
	logic [stlg_pkg::GEN_W-1:0]     g1_q, g2_q, g3_q;
	logic                           seeded_q;
	logic [stlg_pkg::X_W-1:0]       seed_x_q;
	logic [stlg_pkg::ADDR_W-1:0]    fill_idx_q, slot_q;
	logic [1:0]                     pend_q;
	logic                           res_valid_q;
	logic [stlg_pkg::GEN_W-1:0]     coarse_q, fine_q;

	stlg_pkg::stlg_mreq_t           mreq;
	stlg_pkg::stlg_mres_t           mres;

	logic                           ram_we, ram_re;
	logic [stlg_pkg::ADDR_W-1:0]    ram_waddr;
	logic [stlg_pkg::PAIR_W-1:0]    ram_wdata, ram_rdata;

	logic                           req_acc, do_seed, res_free, res_load, fill_last;
	logic [stlg_pkg::X_W-1:0]       seed_ext;

	assign req_acc   = req_valid && !req_stall;
	assign do_seed   = req_type || !seeded_q;
	assign res_free  = !res_valid_q || !res_stall;
	assign fill_last = fill_idx_q == stlg_pkg::ADDR_W'(stlg_pkg::TABLE_DEPTH - 1);
	assign seed_ext  = {{(stlg_pkg::X_W - stlg_pkg::SEED_W){seed[stlg_pkg::SEED_W-1]}}, seed};

	assign req_stall = state_q != stlg_pkg::ST_IDLE;
	assign res_valid = res_valid_q;
	assign coarse    = coarse_q;
	assign fine      = fine_q;

	stlg_modred u_modred (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.mres   (mres)
	);

	stlg_ram #(
		.WIDTH (stlg_pkg::PAIR_W),
		.DEPTH (stlg_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (slot_q),
		.rd_data (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stlg_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = do_seed ? stlg_pkg::ST_SD_RAW : stlg_pkg::ST_DR_S1;
				end
			end
			stlg_pkg::ST_SD_RAW:   state_d = stlg_pkg::ST_SD_RAW_W;
			stlg_pkg::ST_SD_RAW_W: begin
				if (pend_q == 2'd0) begin
					state_d = stlg_pkg::ST_SD_S1A;
				end
			end
			stlg_pkg::ST_SD_S1A:   state_d = stlg_pkg::ST_SD_S1A_W;
			stlg_pkg::ST_SD_S1A_W: begin
				if (pend_q == 2'd0) begin
					state_d = stlg_pkg::ST_SD_D2;
				end
			end
			stlg_pkg::ST_SD_D2:    state_d = stlg_pkg::ST_SD_S1B;
			stlg_pkg::ST_SD_S1B:   state_d = stlg_pkg::ST_SD_S1B_W;
			stlg_pkg::ST_SD_S1B_W: begin
				if (pend_q == 2'd0) begin
					state_d = stlg_pkg::ST_SD_D3;
				end
			end
			stlg_pkg::ST_SD_D3:    state_d = stlg_pkg::ST_FL_S1;
			stlg_pkg::ST_FL_S1:    state_d = stlg_pkg::ST_FL_S2;
			stlg_pkg::ST_FL_S2:    state_d = stlg_pkg::ST_FL_W;
			stlg_pkg::ST_FL_W: begin
				if (pend_q == 2'd0) begin
					state_d = fill_last ? stlg_pkg::ST_DR_S1 : stlg_pkg::ST_FL_S1;
				end
			end
			stlg_pkg::ST_DR_S1:    state_d = stlg_pkg::ST_DR_S2;
			stlg_pkg::ST_DR_S2:    state_d = stlg_pkg::ST_DR_S3;
			stlg_pkg::ST_DR_S3:    state_d = stlg_pkg::ST_DR_W;
			stlg_pkg::ST_DR_W: begin
				if (pend_q == 2'd0) begin
					state_d = stlg_pkg::ST_DR_SL;
				end
			end
			stlg_pkg::ST_DR_SL:    state_d = stlg_pkg::ST_DR_SL_W;
			stlg_pkg::ST_DR_SL_W: begin
				if (pend_q == 2'd0) begin
					state_d = stlg_pkg::ST_DR_RD;
				end
			end
			stlg_pkg::ST_DR_RD:    state_d = stlg_pkg::ST_DR_OUT;
			stlg_pkg::ST_DR_OUT: begin
				if (res_free) begin
					state_d = stlg_pkg::ST_IDLE;
				end
			end
			default:               state_d = stlg_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mreq.valid = 1'b0;
		mreq.op    = stlg_pkg::OP_STEP1;
		mreq.x     = stlg_pkg::X_W'(g1_q);
		ram_we     = 1'b0;
		ram_waddr  = fill_idx_q;
		ram_wdata  = {g1_q, g2_q};
		ram_re     = 1'b0;
		res_load   = 1'b0;
		unique case (state_q) inside
			stlg_pkg::ST_SD_RAW: begin
				mreq.valid = 1'b1;
				mreq.op    = stlg_pkg::OP_SEED;
				mreq.x     = seed_x_q;
			end
			stlg_pkg::ST_SD_S1A, stlg_pkg::ST_SD_S1B, stlg_pkg::ST_FL_S1,
			stlg_pkg::ST_DR_S1: begin
				mreq.valid = 1'b1;
			end
			stlg_pkg::ST_SD_D2: begin
				mreq.valid = 1'b1;
				mreq.op    = stlg_pkg::OP_DER2;
			end
			stlg_pkg::ST_SD_D3: begin
				mreq.valid = 1'b1;
				mreq.op    = stlg_pkg::OP_DER3;
			end
			stlg_pkg::ST_FL_S2, stlg_pkg::ST_DR_S2: begin
				mreq.valid = 1'b1;
				mreq.op    = stlg_pkg::OP_STEP2;
				mreq.x     = stlg_pkg::X_W'(g2_q);
			end
			stlg_pkg::ST_DR_S3: begin
				mreq.valid = 1'b1;
				mreq.op    = stlg_pkg::OP_STEP3;
				mreq.x     = stlg_pkg::X_W'(g3_q);
			end
			stlg_pkg::ST_DR_SL: begin
				mreq.valid = 1'b1;
				mreq.op    = stlg_pkg::OP_SLOT;
				mreq.x     = stlg_pkg::X_W'(g3_q);
			end
			stlg_pkg::ST_FL_W: begin
				ram_we = pend_q == 2'd0;
			end
			stlg_pkg::ST_DR_RD: begin
				ram_re = 1'b1;
			end
			stlg_pkg::ST_DR_OUT: begin
				ram_we    = res_free;
				ram_waddr = slot_q;
				res_load  = res_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stlg_pkg::ST_IDLE;
			seeded_q    <= 1'b0;
			pend_q      <= 2'd0;
			res_valid_q <= 1'b0;
			g1_q        <= '0;
			g2_q        <= '0;
			g3_q        <= '0;
			fill_idx_q  <= '0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_q + 2'(mreq.valid) - 2'(mres.valid);
			if (req_acc && do_seed) begin
				seeded_q <= 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (req_acc) begin
				fill_idx_q <= '0;
			end else if (ram_we && state_q == stlg_pkg::ST_FL_W) begin
				fill_idx_q <= fill_idx_q + 1'b1;
			end
			if (mres.valid) begin
				case (mres.op) inside
					stlg_pkg::OP_SEED, stlg_pkg::OP_STEP1: g1_q <= mres.rem;
					stlg_pkg::OP_STEP2, stlg_pkg::OP_DER2: g2_q <= mres.rem;
					stlg_pkg::OP_STEP3, stlg_pkg::OP_DER3: g3_q <= mres.rem;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			seed_x_q <= stlg_pkg::X_W'(stlg_pkg::ADD_ONE) + stlg_pkg::SEED_BIAS - seed_ext;
		end
		if (mres.valid && mres.op == stlg_pkg::OP_SLOT) begin
			if (mres.quo > stlg_pkg::Q_W'(stlg_pkg::TABLE_DEPTH - 1)) begin
				slot_q <= stlg_pkg::ADDR_W'(stlg_pkg::TABLE_DEPTH - 1);
			end else begin
				slot_q <= mres.quo[stlg_pkg::ADDR_W-1:0];
			end
		end
		if (res_load) begin
			coarse_q <= ram_rdata[stlg_pkg::PAIR_W-1:stlg_pkg::GEN_W];
			fine_q   <= ram_rdata[stlg_pkg::GEN_W-1:0];
		end
	end

endmodule

[design/stlg_checker.sv]
// port-level checker for the shuffled triple lcg generator, bound to the top level
// depends on stlg_pkg and shuffled_triple_lcg_generator_unit_macros.svh
`include "shuffled_triple_lcg_generator_unit_macros.svh"

module stlg_port_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_stall,
	input logic                       res_valid,
	input logic                       res_stall,
	input logic [stlg_pkg::GEN_W-1:0] coarse,
	input logic [stlg_pkg::GEN_W-1:0] fine
);

	`STLG_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(coarse) && $stable(fine))
	`STLG_ASSERT_NOW(a_res_range, res_valid, coarse < stlg_pkg::MOD_ONE && fine < stlg_pkg::MOD_TWO)
	`STLG_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

endmodule

bind shuffled_triple_lcg_generator_unit stlg_port_checker u_stlg_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.coarse    (coarse),
	.fine      (fine)
);
